// ===== sv/swa_pkg.sv =====
package swa_pkg;

  // Sizes of the sample path, the running sum and the window
  localparam int DATA_W     = 32;
  localparam int SUM_W      = 38;
  localparam int LEN_W      = 7;
  localparam int MAX_WINDOW = 64;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int DIV_STEPS  = SUM_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_ABS,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== sv/sliding_window_average_top.sv =====
// Each beat is taken in ST_IDLE and goes through ST_SUB (once the window is full) and ST_ADD; a
// sample that yields an average goes on through ST_ABS, ST_DIV and ST_OUT before out_tvalid
// rises, and a sample that yields no result goes straight back to ST_IDLE for the next beat.
// New beats wait for ST_IDLE, so averaging samples are paced by the 38-step restoring divide on
// the one shared 38-bit adder; the output register lets the next beat in while a result waits.
// Reset (rst_n low, synchronous): window length 1, running sum, fill count and ring pointer
// zero, no result pending. The sample ring is not cleared and needs no clearing pass.
module sliding_window_average_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration: window length k
  input  logic                        cfg_wr_en,
  input  logic [swa_pkg::LEN_W-1:0]   cfg_wr_data,
  // Input samples
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [swa_pkg::DATA_W-1:0]  in_tdata,   // [31:0] sample (signed)
  input  logic                        in_tlast,   // last sample of the sequence
  // Averages
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [swa_pkg::DATA_W-1:0]  out_tdata,  // [31:0] average (signed)
  output logic                        out_tlast   // average of the sequence's last sample
);

  localparam int DATA_W = swa_pkg::DATA_W;
  localparam int SUM_W  = swa_pkg::SUM_W;
  localparam int LEN_W  = swa_pkg::LEN_W;
  localparam int PTR_W  = swa_pkg::PTR_W;
  localparam int CNT_W  = swa_pkg::CNT_W;

  swa_pkg::state_t state_r, state_nxt;

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DATA_W-1:0] sample_r, sample_nxt;
  logic              last_r, last_nxt;
  logic [SUM_W-1:0]  q_r, q_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic              out_tlast_r, out_tlast_nxt;

  // Sample ring with a registered read port
  logic [DATA_W-1:0] ring [swa_pkg::MAX_WINDOW];
  logic [DATA_W-1:0] rd_data_r;
  logic [PTR_W-1:0]  rd_addr;
  logic              ring_we;

  // Shared 38-bit adder/subtractor
  logic [SUM_W-1:0]  add_a, add_b, add_res;
  logic              add_sub;

  logic [LEN_W-1:0]  k_eff;
  logic [LEN_W-1:0]  fill_inc;
  logic [LEN_W-1:0]  rem_shift;
  logic              window_full;

  // Effective window length: zero counts as one, anything above the ring size is clipped
  always_comb begin
    if (len_r == '0) begin
      k_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(swa_pkg::MAX_WINDOW)) begin
      k_eff = LEN_W'(swa_pkg::MAX_WINDOW);
    end else begin
      k_eff = len_r;
    end
  end

  // The oldest sample of the window sits k places behind the write pointer
  assign rd_addr     = wp_r - k_eff[PTR_W-1:0];
  assign window_full = (fill_r >= k_eff);
  assign fill_inc    = window_full ? fill_r : fill_r + LEN_W'(1);
  assign rem_shift   = {rem_r[LEN_W-2:0], q_r[SUM_W-1]};

  // Operand selection for the shared adder
  always_comb begin
    add_a   = sum_r;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      swa_pkg::ST_SUB: begin
        add_a   = sum_r;
        add_b   = {{(SUM_W-DATA_W){rd_data_r[DATA_W-1]}}, rd_data_r};
        add_sub = 1'b1;
      end
      swa_pkg::ST_ADD: begin
        add_a   = sum_r;
        add_b   = {{(SUM_W-DATA_W){sample_r[DATA_W-1]}}, sample_r};
        add_sub = 1'b0;
      end
      swa_pkg::ST_ABS: begin
        add_a   = '0;
        add_b   = sum_r;
        add_sub = 1'b1;
      end
      swa_pkg::ST_DIV: begin
        add_a   = {{(SUM_W-LEN_W){1'b0}}, rem_shift};
        add_b   = {{(SUM_W-LEN_W){1'b0}}, k_eff};
        add_sub = 1'b1;
      end
      swa_pkg::ST_OUT: begin
        add_a   = '0;
        add_b   = q_r;
        add_sub = 1'b1;
      end
      default: begin
        add_a   = sum_r;
        add_b   = '0;
        add_sub = 1'b0;
      end
    endcase
    add_res = add_sub ? add_a - add_b : add_a + add_b;
  end

  assign in_tready = (state_r == swa_pkg::ST_IDLE);

  // Sequencer: next state and register updates
  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    fill_nxt       = fill_r;
    wp_nxt         = wp_r;
    sum_nxt        = sum_r;
    sample_nxt     = sample_r;
    last_nxt       = last_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    neg_nxt        = neg_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    ring_we        = 1'b0;

    unique case (state_r)
      swa_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          sample_nxt = in_tdata;
          last_nxt   = in_tlast;
          state_nxt  = window_full ? swa_pkg::ST_SUB : swa_pkg::ST_ADD;
        end
      end
      // Drop the oldest sample from the running sum
      swa_pkg::ST_SUB: begin
        sum_nxt   = add_res;
        state_nxt = swa_pkg::ST_ADD;
      end
      // Store the new sample and add it in
      swa_pkg::ST_ADD: begin
        ring_we  = 1'b1;
        wp_nxt   = wp_r + PTR_W'(1);
        sum_nxt  = add_res;
        fill_nxt = fill_inc;
        if (fill_inc >= k_eff) begin
          state_nxt = swa_pkg::ST_ABS;
        end else begin
          if (last_r) begin
            fill_nxt = '0;
            sum_nxt  = '0;
          end
          state_nxt = swa_pkg::ST_IDLE;
        end
      end
      // Take the magnitude of the sum as the dividend
      swa_pkg::ST_ABS: begin
        neg_nxt   = sum_r[SUM_W-1];
        q_nxt     = sum_r[SUM_W-1] ? add_res : sum_r;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        if (last_r) begin
          fill_nxt = '0;
          sum_nxt  = '0;
        end
        state_nxt = swa_pkg::ST_DIV;
      end
      // One restoring divide step per cycle, quotient shifts in from the bottom
      swa_pkg::ST_DIV: begin
        if (!add_res[SUM_W-1]) begin
          rem_nxt = add_res[LEN_W-1:0];
          q_nxt   = {q_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_shift;
          q_nxt   = {q_r[SUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(swa_pkg::DIV_STEPS - 1)) begin
          state_nxt = swa_pkg::ST_OUT;
        end
      end
      // Restore the sign and hand the result to the output register once it is free
      swa_pkg::ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = neg_r ? add_res[DATA_W-1:0] : q_r[DATA_W-1:0];
          out_tlast_nxt  = last_r;
          state_nxt      = swa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swa_pkg::ST_IDLE;
      end
    endcase

    // A new window length starts a fresh sequence
    if (cfg_wr_en) begin
      len_nxt  = cfg_wr_data;
      fill_nxt = '0;
      sum_nxt  = '0;
    end
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= swa_pkg::ST_IDLE;
      len_r        <= LEN_W'(1);
      fill_r       <= '0;
      wp_r         <= '0;
      sum_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      fill_r       <= fill_nxt;
      wp_r         <= wp_nxt;
      sum_r        <= sum_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    sample_r    <= sample_nxt;
    last_r      <= last_nxt;
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    neg_r       <= neg_nxt;
    cnt_r       <= cnt_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  // Ring write and registered read
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[wp_r] <= sample_r;
    end
    rd_data_r <= ring[rd_addr];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ===== tb/sv/window_average_checker.sv =====
`timescale 1ns / 100ps

// Watches the window-length writes and both the sample and result streams, keeps its own
// copy of the averaging state and checks every result beat against it.
module window_average_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [swa_pkg::LEN_W-1:0]  cfg_wr_data,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [swa_pkg::DATA_W-1:0] in_tdata,   // [31:0] sample (signed)
  input  logic                       in_tlast,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [swa_pkg::DATA_W-1:0] out_tdata,  // [31:0] average (signed)
  input  logic                       out_tlast,
  output int                         mismatch_count,
  output int                         averages_pending,
  output int                         averages_checked
);

  localparam int DATA_W     = swa_pkg::DATA_W;
  localparam int SUM_W      = swa_pkg::SUM_W;
  localparam int LEN_W      = swa_pkg::LEN_W;
  localparam int PTR_W      = swa_pkg::PTR_W;
  localparam int MAX_WINDOW = swa_pkg::MAX_WINDOW;

  typedef struct packed {
    logic signed [DATA_W-1:0] average;
    logic                     seq_end;
  } average_t;

  average_t                 expected_averages[$];
  average_t                 oldest;
  logic signed [DATA_W-1:0] sample_history [MAX_WINDOW];
  logic signed [SUM_W-1:0]  window_sum;
  logic [LEN_W-1:0]         window_len;
  logic [LEN_W-1:0]         fill;
  logic [PTR_W-1:0]         wr_ptr;
  int                       mismatches;
  int                       checked;

  // A length of zero acts as one and anything above the ring size as the ring size.
  function automatic logic [LEN_W-1:0] active_len();
    if (window_len == '0) begin
      return LEN_W'(1);
    end
    if (window_len > LEN_W'(MAX_WINDOW)) begin
      return LEN_W'(MAX_WINDOW);
    end
    return window_len;
  endfunction

  // Slides the window over one sample and queues the average it yields, if any.
  task automatic slide_window(input logic signed [DATA_W-1:0] sample, input logic seq_last);
    logic [LEN_W-1:0]        k;
    logic signed [SUM_W-1:0] divisor;
    logic signed [SUM_W-1:0] quotient;
    average_t                predicted;
    k = active_len();
    // The sample leaving the window sits k places behind the write pointer.
    if (fill >= k) begin
      window_sum = window_sum - sample_history[wr_ptr - PTR_W'(k)];
    end
    sample_history[wr_ptr] = sample;
    wr_ptr = wr_ptr + 1'b1;
    window_sum = window_sum + sample;
    if (fill < k) begin
      fill = fill + 1'b1;
    end
    if (fill >= k) begin
      divisor = SUM_W'(k);
      // Signed division truncates toward zero, as the block does.
      quotient = window_sum / divisor;
      predicted.average = quotient[DATA_W-1:0];
      predicted.seq_end = seq_last;
      expected_averages.push_back(predicted);
    end
    if (seq_last) begin
      fill = '0;
      window_sum = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_averages.delete();
      window_sum = '0;
      window_len = LEN_W'(1);
      fill = '0;
      wr_ptr = '0;
      mismatches = 0;
      checked = 0;
    end else begin
      // Each result beat is held against the oldest average still owed.
      if (out_tvalid && out_tready) begin
        checked++;
        if (expected_averages.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected average %0d (last %0b) with nothing owed",
                     $realtime, $signed(out_tdata), out_tlast);
          end
          mismatches++;
        end else begin
          oldest = expected_averages.pop_front();
          if (out_tdata !== oldest.average || out_tlast !== oldest.seq_end) begin
            if (mismatches < 10) begin
              $display("%0t: average mismatch: expected %0d (last %0b), got %0d (last %0b)",
                       $realtime, oldest.average, oldest.seq_end, $signed(out_tdata),
                       out_tlast);
            end
            mismatches++;
          end
        end
      end
      // A length write restarts the sequence.
      if (cfg_wr_en) begin
        window_len = cfg_wr_data;
        fill = '0;
        window_sum = '0;
      end
      if (in_tvalid && in_tready) begin
        slide_window($signed(in_tdata), in_tlast);
      end
    end
    mismatch_count   <= mismatches;
    averages_pending <= expected_averages.size();
    averages_checked <= checked;
  end

endmodule

// ===== tb/sv/sliding_window_average_top_test.sv =====
`timescale 1ns / 100ps

module sliding_window_average_top_test;

  localparam int DATA_W         = swa_pkg::DATA_W;
  localparam int LEN_W          = swa_pkg::LEN_W;
  localparam int MAX_WINDOW     = swa_pkg::MAX_WINDOW;
  localparam int SETTLE_CYCLES  = 50;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SAMPLE_TARGET  = 1150;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [LEN_W-1:0]  cfg_wr_data = '0;
  logic              in_tvalid   = 1'b0;
  logic [DATA_W-1:0] in_tdata    = '0;
  logic              in_tlast    = 1'b0;
  logic              out_tready  = 1'b0;
  logic              in_tready;
  logic              out_tvalid;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tlast;

  int mismatch_count;
  int averages_pending;
  int averages_checked;
  int samples_sent   = 0;
  int sequences_sent = 0;
  int settings_used  = 0;
  bit sender_fast    = 1'b0;
  bit hold_request   = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sliding_window_average_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  window_average_checker avg_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tlast         (in_tlast),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tlast        (out_tlast),
    .mismatch_count   (mismatch_count),
    .averages_pending (averages_pending),
    .averages_checked (averages_checked)
  );

  // Sample values: rail extremes, small values around zero, values near the top, or anything.
  function automatic logic [DATA_W-1:0] draw_sample(input int flavour);
    case (flavour)
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return DATA_W'($urandom_range(0, 40)) - DATA_W'(20);
      2: return 32'h7FFF_FFFF - DATA_W'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  // Offers one sample after a random gap; valid stays high when there is no gap.
  task automatic send_sample(input logic [DATA_W-1:0] value, input logic seq_last);
    int gap;
    gap = sender_fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= value;
    in_tlast  <= seq_last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    if (seq_last) begin
      sequences_sent++;
    end
  endtask

  // Stops offering until every owed average has come out and the block has settled.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (averages_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [LEN_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // One sequence; halfway through it may pause for a drain or rewrite the window length.
  task automatic send_sequence(input int length, input int flavour, input int midway,
                               input logic [LEN_W-1:0] setting);
    int mix;
    for (int i = 0; i < length; i++) begin
      if (i == length / 2 && i > 0) begin
        if (midway == 1) begin
          drain_results();
        end else if (midway == 2) begin
          write_window(setting);
        end
      end
      mix = (flavour == 4) ? $urandom_range(0, 3) : flavour;
      send_sample(draw_sample(mix), i == length - 1);
    end
  endtask

  // Result side: random stalls per beat, runs with none, and one long hold-off on request.
  initial begin
    int  stall;
    int  served;
    bit  fast;
    served = 0;
    fast = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (served % 32 == 0) begin
        fast = ($urandom_range(0, 3) == 0);
      end
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      stall = fast ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      served++;
    end
  end

  // Ends the run when no beat and no write has been seen for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timed out after %0d cycles without a beat", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int               phase;
    int               k_eff;
    int               sequences;
    int               length;
    int               midway;
    logic [LEN_W-1:0] setting;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset length of one: every sample is its own average, rails included.
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0000_0001, 1'b1);

    // Length two: sums beyond 32 bits and rounding of negative halves toward zero.
    write_window(LEN_W'(2));
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFD, 1'b0);
    send_sample(32'h0000_0000, 1'b1);

    // Length zero behaves as one.
    write_window(LEN_W'(0));
    send_sample(32'h0000_0005, 1'b0);
    send_sample(32'hFFFF_FFFB, 1'b1);

    // A write in the middle of a sequence starts the window afresh.
    write_window(LEN_W'(3));
    send_sample(32'h0000_000A, 1'b0);
    send_sample(32'h0000_0014, 1'b0);
    write_window(LEN_W'(3));
    send_sample(32'h0000_001E, 1'b0);
    send_sample(32'h0000_0028, 1'b0);
    send_sample(32'h0000_0032, 1'b1);

    // A sequence ending before the window fills gives nothing; the next one starts clean.
    send_sample(32'h0000_0007, 1'b0);
    send_sample(32'h0000_0008, 1'b1);
    send_sample(32'h0000_0009, 1'b0);
    send_sample(32'h0000_000A, 1'b0);
    send_sample(32'h0000_000B, 1'b1);

    // Random phases, each under its own window length.
    phase = 0;
    while (samples_sent < SAMPLE_TARGET) begin
      phase++;
      case (phase)
        1: setting = LEN_W'(MAX_WINDOW);
        2: setting = '1;
        3: setting = LEN_W'(1);
        default: begin
          case ($urandom_range(0, 9))
            0: setting = '0;
            1: setting = LEN_W'(MAX_WINDOW);
            2: setting = LEN_W'($urandom_range(MAX_WINDOW + 1, 127));
            3, 4: setting = LEN_W'($urandom_range(9, MAX_WINDOW));
            default: setting = LEN_W'($urandom_range(1, 8));
          endcase
        end
      endcase
      write_window(setting);
      if (setting == '0) begin
        k_eff = 1;
      end else if (setting > LEN_W'(MAX_WINDOW)) begin
        k_eff = MAX_WINDOW;
      end else begin
        k_eff = int'(setting);
      end
      sender_fast = ($urandom_range(0, 3) == 0);
      // With a window of one every sample yields a result, so the hold-off fills the block.
      if (phase == 3) begin
        hold_request = 1'b1;
      end
      sequences = (k_eff > 16) ? 2 : $urandom_range(3, 8);
      repeat (sequences) begin
        if (k_eff > 1 && $urandom_range(0, 5) == 0) begin
          length = $urandom_range(1, k_eff - 1);
        end else begin
          length = k_eff + $urandom_range(0, 24);
        end
        if ($urandom_range(0, 9) == 0) begin
          midway = 1;
        end else if ($urandom_range(0, 9) == 0) begin
          midway = 2;
        end else begin
          midway = 0;
        end
        send_sequence(length, $urandom_range(0, 4), midway, setting);
      end
    end

    drain_results();
    $display("Fed %0d samples in %0d sequences under %0d window-length writes; %0d averages",
             samples_sent, sequences_sent, settings_used, averages_checked);
    $display("came back, with lengths from zero to beyond the ring and one %0d-cycle output hold.",
             HOLD_CYCLES);
    if (mismatch_count == 0 && averages_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/swa_pkg.sv
sv/sliding_window_average_top.sv
tb/sv/window_average_checker.sv
tb/sv/sliding_window_average_top_test.sv
